[hdl/fov_sector_coverage_marker_defines.svh]
// Assertion macros for the sector coverage marker.
`ifndef FOV_SECTOR_COVERAGE_MARKER_DEFINES_SVH
`define FOV_SECTOR_COVERAGE_MARKER_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define FSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsc: assertion failed");
// Condition in one cycle implies a condition in the next.
`define FSC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("fsc: assertion failed");
`else
`define FSC_ASSERT(lbl, prop)
`define FSC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

[hdl/fsc_pkg.sv]
// Types and constants shared by the sector coverage marker modules.
`timescale 1ns / 1ps
package fsc_pkg;

  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] CFG_GRID_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_RANGE_CELLS    = 3'd2;
  localparam logic [2:0] CFG_MAX_DIST_SQ    = 3'd3;
  localparam logic [2:0] CFG_HALF_FOV       = 3'd4;
  localparam logic [2:0] CFG_HEADING_OFFSET = 3'd5;

  localparam logic [6:0] COVERED_VALUE = 7'd100;

  localparam int CORDIC_STEPS = 15;
  localparam int CORDIC_XW    = 26;

  localparam logic [15:0] ATAN_BAU [0:CORDIC_STEPS-1] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
  };

  // Per-cell information carried alongside the bearing pipeline.
  typedef struct packed {
    logic        keep;
    logic        zero;
    logic [16:0] idx;
  } fsc_side_t;

endpackage

[hdl/fsc_cordic.sv]
// Pipelined CORDIC that finds the bearing of a cell offset in binary angle units.
`timescale 1ns / 1ps
module fsc_cordic import fsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic signed [8:0] in_dx,
  input  logic signed [8:0] in_dy,
  input  fsc_side_t         in_side,
  output logic              out_valid,
  output fsc_side_t         out_side,
  output logic [15:0]       out_z
);

  logic signed [CORDIC_XW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CORDIC_XW-1:0] y_r [0:CORDIC_STEPS];
  logic        [15:0]          z_r [0:CORDIC_STEPS];
  logic                        v_r [0:CORDIC_STEPS];
  fsc_side_t                   s_r [0:CORDIC_STEPS];

  logic signed [8:0] dxn, dyn;
  logic              neg;

  // Vectors in the left half-plane are turned by half a turn first.
  assign neg = in_dx[8];
  assign dxn = neg ? -in_dx : in_dx;
  assign dyn = neg ? -in_dy : in_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    x_r[0] <= CORDIC_XW'(dxn) <<< 14;
    y_r[0] <= CORDIC_XW'(dyn) <<< 14;
    z_r[0] <= neg ? 16'h8000 : 16'h0000;
    s_r[0] <= in_side;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      if (!y_r[i][CORDIC_XW-1]) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN_BAU[i];
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN_BAU[i];
      end
      s_r[i+1] <= s_r[i];
    end
  end

  assign out_valid = v_r[CORDIC_STEPS];
  assign out_side  = s_r[CORDIC_STEPS];
  assign out_z     = z_r[CORDIC_STEPS];

endmodule

[hdl/fov_sector_coverage_marker.sv]
// Top level of the sector coverage marker: control, cell walk and coverage memory.
`timescale 1ns / 1ps
`include "fov_sector_coverage_marker_defines.svh"
// One coverage bit per grid cell is held in a single-port-write, registered-read
// memory of GRID_CELLS bits. Items are taken one at a time. A mark walks the
// (2R+1) x (2R+1) window at one cell per cycle through walk stage 1 and the
// CORDIC bearing pipeline. A read passes through S_RDA and S_RDW, and a clear
// sweeps the memory one bit a cycle; a result still waiting in the output
// register holds the item in S_DONE. After reset the same sweep runs before
// the first input beat is taken; configuration writes are taken throughout.
module fov_sector_coverage_marker import fsc_pkg::*; #(
  parameter int GRID_CELLS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_robot_col,
  input  logic signed [15:0] in_robot_row,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_coverage_value
);

  localparam int          AW        = $clog2(GRID_CELLS);
  localparam logic [31:0] CELLS32   = 32'(GRID_CELLS);
  localparam logic [AW-1:0] LAST    = AW'(GRID_CELLS - 1);
  localparam logic [4:0]  DRAIN_CYC = 5'd20;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MARK  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_RDA   = 7'b0010000,
    S_RDW   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [8:0]  grid_width_r, grid_height_r;
  logic [7:0]  range_cells_r;
  logic [16:0] max_dist_sq_r;
  logic [15:0] half_fov_r, heading_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= 9'd256;
      grid_height_r    <= 9'd256;
      range_cells_r    <= 8'd100;
      max_dist_sq_r    <= 17'd10000;
      half_fov_r       <= 16'd5461;
      heading_offset_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:     grid_width_r     <= cfg_wdata[8:0];
        CFG_GRID_HEIGHT:    grid_height_r    <= cfg_wdata[8:0];
        CFG_RANGE_CELLS:    range_cells_r    <= cfg_wdata[7:0];
        CFG_MAX_DIST_SQ:    max_dist_sq_r    <= cfg_wdata;
        CFG_HALF_FOV:       half_fov_r       <= cfg_wdata[15:0];
        CFG_HEADING_OFFSET: heading_offset_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [8:0] w_sat, h_sat;
  assign w_sat = (grid_width_r  > 9'd256) ? 9'd256 : grid_width_r;
  assign h_sat = (grid_height_r > 9'd256) ? 9'd256 : grid_height_r;

  // Item registers and control.
  logic signed [15:0] col_r, row_r;
  logic [15:0]        aim_r, cell_idx_r;
  logic signed [8:0]  cdx_r, cdy_r, cdx_nxt, cdy_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic [4:0]         drain_r, drain_nxt;
  logic [6:0]         res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_value_r, out_value_nxt;
  logic               accept;
  logic signed [8:0]  rng;

  assign rng       = $signed({1'b0, range_cells_r});
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_coverage_value = out_value_r;

  // Walk stage 1: offsets, squares and grid test.
  logic               s1_valid_r;
  logic signed [8:0]  s1_dx_r, s1_dy_r;
  logic [16:0]        s1_dxsq_r, s1_dysq_r;
  logic [7:0]         s1_nx_r, s1_ny_r;
  logic               s1_ingrid_r;
  logic signed [16:0] nx, ny;
  logic signed [17:0] dxsq, dysq;
  logic               ingrid;

  assign nx     = 17'(col_r) + 17'(cdx_r);
  assign ny     = 17'(row_r) + 17'(cdy_r);
  assign dxsq   = cdx_r * cdx_r;
  assign dysq   = cdy_r * cdy_r;
  assign ingrid = !nx[16] && !ny[16] && (nx < $signed({8'b0, w_sat}))
                  && (ny < $signed({8'b0, h_sat}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == S_MARK);
    end
    s1_dx_r     <= cdx_r;
    s1_dy_r     <= cdy_r;
    s1_dxsq_r   <= dxsq[16:0];
    s1_dysq_r   <= dysq[16:0];
    s1_nx_r     <= nx[7:0];
    s1_ny_r     <= ny[7:0];
    s1_ingrid_r <= ingrid;
  end

  // Walk stage 2: distance test and cell index, into the bearing pipeline.
  fsc_side_t   side_in, side_out;
  logic [17:0] dsq;
  logic        c_valid;
  logic [15:0] c_z;

  assign dsq          = {1'b0, s1_dxsq_r} + {1'b0, s1_dysq_r};
  assign side_in.keep = s1_ingrid_r && (dsq <= {1'b0, max_dist_sq_r});
  assign side_in.zero = (s1_dx_r == 9'sd0) && (s1_dy_r == 9'sd0);
  assign side_in.idx  = ({9'b0, s1_ny_r} * {8'b0, w_sat}) + {9'b0, s1_nx_r};

  fsc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_dx     (s1_dx_r),
    .in_dy     (s1_dy_r),
    .in_side   (side_in),
    .out_valid (c_valid),
    .out_side  (side_out),
    .out_z     (c_z)
  );

  // Field-of-view test and write of the covered bit.
  logic [15:0] bearing, diff;
  logic [16:0] mag;
  logic [31:0] mark_idx32;
  logic        mark_we;

  assign bearing    = side_out.zero ? 16'd0 : c_z;
  assign diff       = bearing - aim_r;
  assign mag        = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
  assign mark_idx32 = {15'b0, side_out.idx};
  assign mark_we    = c_valid && side_out.keep && (mag <= {1'b0, half_fov_r})
                      && (mark_idx32 < CELLS32);

  // Coverage memory.
  logic          mem [0:GRID_CELLS-1];
  logic          mem_we, mem_wd, mem_re, mem_rd_r;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   rd_idx32;

  assign rd_idx32 = {16'b0, cell_idx_r};
  assign mem_we   = (state_r == S_CLEAR) || mark_we;
  assign mem_wd   = (state_r != S_CLEAR);
  assign mem_wa   = (state_r == S_CLEAR) ? clr_cnt_r : mark_idx32[AW-1:0];
  assign mem_re   = (state_r == S_RDA);
  assign mem_ra   = rd_idx32[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cdx_nxt       = cdx_r;
    cdy_nxt       = cdy_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_resp_nxt  = clr_resp_r;
    drain_nxt     = drain_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_resp_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_nxt = 7'd0;
          cdx_nxt = -rng;
          cdy_nxt = -rng;
          unique case (in_operation)
            OP_MARK:  state_nxt = S_MARK;
            OP_READ:  state_nxt = S_RDA;
            OP_CLEAR: begin
              state_nxt    = S_CLEAR;
              clr_resp_nxt = 1'b1;
            end
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_MARK: begin
        if (cdx_r == rng) begin
          cdx_nxt = -rng;
          cdy_nxt = cdy_r + 9'sd1;
          if (cdy_r == rng) begin
            state_nxt = S_DRAIN;
            drain_nxt = DRAIN_CYC;
          end
        end else begin
          cdx_nxt = cdx_r + 9'sd1;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r - 5'd1;
        if (drain_r == 5'd0) begin
          state_nxt = S_DONE;
        end
      end
      S_RDA: state_nxt = S_RDW;
      S_RDW: begin
        res_nxt   = ((rd_idx32 < CELLS32) && mem_rd_r) ? COVERED_VALUE : 7'd0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          clr_resp_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      drain_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_resp_r  <= clr_resp_nxt;
      out_valid_r <= out_valid_nxt;
      drain_r     <= drain_nxt;
    end
    cdx_r       <= cdx_nxt;
    cdy_r       <= cdy_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    if (accept) begin
      col_r      <= in_robot_col;
      row_r      <= in_robot_row;
      aim_r      <= in_heading + heading_offset_r;
      cell_idx_r <= in_cell_index;
    end
  end

  // The bearing pipeline must be empty before a result is given.
  `FSC_ASSERT(a_drained, (state_r == S_DONE) |-> !c_valid)
  // Only the mark walk sets coverage bits.
  `FSC_ASSERT(a_set_in_mark, (mem_we && mem_wd) |-> (state_r == S_MARK || state_r == S_DRAIN))
  // No memory write is in flight while a new beat is taken.
  `FSC_ASSERT(a_idle_quiet, accept |-> !mem_we)
  // A finished item always leaves a result register loaded.
  `FSC_ASSERT_NEXT(a_result_loaded, (state_r == S_DONE) && (state_nxt == S_IDLE), out_valid_r)

endmodule
